### rtl/sld_pkg.sv
// Shared types, constants and operation codes of the styled run line decoder.
package sld_pkg;

    // Default longest line accepted, in cells
    localparam int MAX_LINE_DEF = 1024;

    // Run store geometry: index wraps at the store depth
    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Width of the column field of a result
    localparam int COL_W = 10;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Operations passed from front to back
    localparam logic [2:0] OP_RUN   = 3'd0;  // store a run, optionally then start cells
    localparam logic [2:0] OP_START = 3'd1;  // start emitting cells of the line
    localparam logic [2:0] OP_CELL  = 3'd2;  // emit one styled cell
    localparam logic [2:0] OP_EMPTY = 3'd3;  // emit an empty-line marker
    localparam logic [2:0] OP_ERROR = 3'd4;  // emit an error

    // Result kinds
    localparam logic [1:0] KIND_CELL  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error causes
    localparam logic [1:0] CAUSE_TRUNC    = 2'd0;
    localparam logic [1:0] CAUSE_OVERFLOW = 2'd1;
    localparam logic [1:0] CAUSE_SHORT    = 2'd2;
    localparam logic [1:0] CAUSE_TOO_LONG = 2'd3;

    // One input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_end;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       error_cause;
        logic [31:0]      char_code;
        logic [31:0]      fore_color;
        logic [31:0]      back_color;
        logic [15:0]      attr_bits;
        logic [COL_W-1:0] column;
        logic             last_in_line;
    } res_t;

    // One queued operation; the cell count travels beside it
    typedef struct packed {
        logic [2:0]          op;
        logic                start;
        logic [1:0]          cause;
        logic                last;
        logic [STORE_AW-1:0] idx;
        logic [31:0]         data_a;
        logic [31:0]         data_b;
        logic [15:0]         attr;
    } op_t;

endpackage

### rtl/style_run_line_decoder_unit.sv
// Top level of the styled run line decoder: front, queue and back.
//
// Input channel item_valid/item_ready/item carries one byte of an encoded
// chunk per transaction, with chunk_end on the last byte of the chunk.
// Result channel res_valid/res_ready/res carries a styled cell, an empty-line
// marker or an error. A byte yields at most one result.
// Throughput: one byte per cycle sustained while the queue is not full. A
// byte moves through the front in its accept cycle, waits in a 4-entry
// operation queue, and the back registers its result.
// Each cell looks up its style in a 1024-entry run store with a registered
// read; the back keeps the current and the following run prefetched, and
// fetches them anew after the last run count of a line and after each run change.
// Cells wait in the queue also while that prefetch has not finished.
// When the receiver stalls, the result register holds and the queue fills;
// item_ready drops once the queue is full.
// Reset clears the control state: the decoder expects a line length and the
// run store contents stay undefined; no line uses an entry it did not write.
module style_run_line_decoder_unit #(
    parameter int MAX_LINE = sld_pkg::MAX_LINE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  sld_pkg::item_t item,
    output logic           res_valid,
    input  logic           res_ready,
    output sld_pkg::res_t  res
);

    localparam int CNT_W = $clog2(MAX_LINE + 1);

    logic             push;
    sld_pkg::op_t     push_op;
    logic [CNT_W-1:0] push_cnt;
    logic             q_full;
    logic             q_valid;
    sld_pkg::op_t     q_op;
    logic [CNT_W-1:0] q_cnt;
    logic             q_pop;

    sld_front #(
        .MAX_LINE (MAX_LINE),
        .CNT_W    (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .op_push    (push),
        .op         (push_op),
        .op_cnt     (push_cnt),
        .q_full     (q_full)
    );

    sld_queue #(
        .CNT_W (CNT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .push_cnt   (push_cnt),
        .full       (q_full),
        .head_valid (q_valid),
        .head_op    (q_op),
        .head_cnt   (q_cnt),
        .pop        (q_pop)
    );

    sld_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_cnt     (q_cnt),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

### rtl/sld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sld_queue.sv
// Short operation queue between the decoder front and back.
module sld_queue #(
    parameter int CNT_W = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sld_pkg::op_t       push_op,
    input  logic [CNT_W-1:0]   push_cnt,
    output logic               full,
    output logic               head_valid,
    output sld_pkg::op_t       head_op,
    output logic [CNT_W-1:0]   head_cnt,
    input  logic               pop
);

    localparam int DEPTH = sld_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W = $clog2(DEPTH + 1);

    sld_pkg::op_t     op_mem_reg  [DEPTH];
    logic [CNT_W-1:0] cnt_mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NUM_W-1:0] num_reg, num_next;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        num_next    = num_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            num_next = num_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            num_next = num_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            num_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            num_reg    <= num_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem_reg[wr_ptr_reg]  <= push_op;
            cnt_mem_reg[wr_ptr_reg] <= push_cnt;
        end
    end

    assign full       = (num_reg == NUM_W'(DEPTH));
    assign head_valid = (num_reg != '0);
    assign head_op    = op_mem_reg[rd_ptr_reg];
    assign head_cnt   = cnt_mem_reg[rd_ptr_reg];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

### rtl/sld_front.sv
// Decoder front: assembles words from bytes, tracks the line format, checks it.
module sld_front #(
    parameter int MAX_LINE = sld_pkg::MAX_LINE_DEF,
    parameter int CNT_W    = $clog2(MAX_LINE + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sld_pkg::item_t     item,
    output logic               op_push,
    output sld_pkg::op_t       op,
    output logic [CNT_W-1:0]   op_cnt,
    input  logic               q_full
);

    // Line format phases
    localparam logic [2:0] PH_LEN   = 3'd0;
    localparam logic [2:0] PH_NRUNS = 3'd1;
    localparam logic [2:0] PH_FORE  = 3'd2;
    localparam logic [2:0] PH_BACK  = 3'd3;
    localparam logic [2:0] PH_ATTR  = 3'd4;
    localparam logic [2:0] PH_COUNT = 3'd5;
    localparam logic [2:0] PH_CODE  = 3'd6;

    localparam int AW = sld_pkg::STORE_AW;

    logic [2:0]       phase_reg, phase_next;
    logic [31:0]      shift_reg, shift_next;
    logic [1:0]       bcnt_reg, bcnt_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [31:0]      runs_reg, runs_next;
    logic [CNT_W-1:0] filled_reg, filled_next;
    logic [31:0]      pfore_reg, pfore_next;
    logic [31:0]      pback_reg, pback_next;
    logic [15:0]      pattr_reg, pattr_next;
    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic             disc_reg, disc_next;

    logic             accept;
    logic             is_attr;
    logic             done;
    logic [31:0]      shifted;
    logic [31:0]      word;
    logic [CNT_W-1:0] rem;
    logic [31:0]      runs_new;
    logic [CNT_W-1:0] filled_new;
    logic             store;
    logic [CNT_W-1:0] emitted_inc;
    logic             last_cell;
    logic             err_hit;
    logic [1:0]       err_cause;
    logic             restart;

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;

    // Word assembly, little-endian
    assign is_attr = (phase_reg == PH_ATTR);
    assign shifted = {item.in_byte, shift_reg[31:8]};
    assign done    = is_attr ? (bcnt_reg == 2'd1) : (bcnt_reg == 2'd3);
    assign word    = is_attr ? {16'h0000, shifted[31:16]} : shifted;

    // Run bookkeeping values for a completed run count or count word
    assign rem         = len_reg - filled_reg;
    assign runs_new    = (phase_reg == PH_NRUNS) ? word : runs_reg - 32'd1;
    assign filled_new  = (phase_reg == PH_NRUNS) ? '0 : filled_reg + word[CNT_W-1:0];
    assign store       = (phase_reg == PH_COUNT) && (word != 32'd0);
    assign emitted_inc = emitted_reg + 1'b1;
    assign last_cell   = (emitted_inc == len_reg);

    // Per-byte decode
    always_comb
    begin
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        bcnt_next    = bcnt_reg;
        len_next     = len_reg;
        runs_next    = runs_reg;
        filled_next  = filled_reg;
        pfore_next   = pfore_reg;
        pback_next   = pback_reg;
        pattr_next   = pattr_reg;
        wr_idx_next  = wr_idx_reg;
        emitted_next = emitted_reg;
        disc_next    = disc_reg;
        op_push      = 1'b0;
        op           = '0;
        op_cnt       = '0;
        err_hit      = 1'b0;
        err_cause    = sld_pkg::CAUSE_TRUNC;
        restart      = 1'b0;

        if (accept)
        begin
            if (disc_reg)
            begin
                // Dropping bytes until the chunk ends
                if (item.chunk_end)
                begin
                    disc_next = 1'b0;
                    restart   = 1'b1;
                end
            end
            else
            begin
                shift_next = shifted;
                bcnt_next  = done ? 2'd0 : bcnt_reg + 2'd1;
                if (done)
                begin
                    unique case (phase_reg)
                        PH_NRUNS, PH_COUNT:
                        begin
                            if ((phase_reg == PH_COUNT) && (word > 32'(rem)))
                            begin
                                err_hit   = 1'b1;
                                err_cause = sld_pkg::CAUSE_OVERFLOW;
                            end
                            else
                            begin
                                runs_next   = runs_new;
                                filled_next = filled_new;
                                if (phase_reg == PH_NRUNS)
                                begin
                                    wr_idx_next = '0;
                                end
                                if (store)
                                begin
                                    wr_idx_next = wr_idx_reg + 1'b1;
                                    op.op       = sld_pkg::OP_RUN;
                                    op.idx      = wr_idx_reg;
                                    op.data_a   = pfore_reg;
                                    op.data_b   = pback_reg;
                                    op.attr     = pattr_reg;
                                    op_cnt      = filled_new;
                                end
                                if (runs_new != 32'd0)
                                begin
                                    phase_next = PH_FORE;
                                    op_push    = store;
                                end
                                else if (filled_new != len_reg)
                                begin
                                    err_hit   = 1'b1;
                                    err_cause = sld_pkg::CAUSE_SHORT;
                                end
                                else if (len_reg == '0)
                                begin
                                    op_push = 1'b1;
                                    op      = '0;
                                    op.op   = sld_pkg::OP_EMPTY;
                                    restart = 1'b1;
                                end
                                else
                                begin
                                    phase_next   = PH_CODE;
                                    emitted_next = '0;
                                    op_push      = 1'b1;
                                    if (store)
                                    begin
                                        op.start = 1'b1;
                                    end
                                    else
                                    begin
                                        op.op = sld_pkg::OP_START;
                                    end
                                end
                            end
                        end
                        PH_FORE:
                        begin
                            pfore_next = word;
                            phase_next = PH_BACK;
                        end
                        PH_BACK:
                        begin
                            pback_next = word;
                            phase_next = PH_ATTR;
                        end
                        PH_ATTR:
                        begin
                            pattr_next = word[15:0];
                            phase_next = PH_COUNT;
                        end
                        PH_CODE:
                        begin
                            op_push      = 1'b1;
                            op.op        = sld_pkg::OP_CELL;
                            op.data_a    = word;
                            op.last      = last_cell;
                            op_cnt       = emitted_reg;
                            emitted_next = emitted_inc;
                            if (last_cell)
                            begin
                                restart = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Line length word
                            if (word > 32'(MAX_LINE))
                            begin
                                err_hit   = 1'b1;
                                err_cause = sld_pkg::CAUSE_TOO_LONG;
                            end
                            else
                            begin
                                len_next   = word[CNT_W-1:0];
                                phase_next = PH_NRUNS;
                            end
                        end
                    endcase
                end

                // Errors replace whatever the byte would have produced
                if (err_hit)
                begin
                    op_push   = 1'b1;
                    op        = '0;
                    op.op     = sld_pkg::OP_ERROR;
                    op.cause  = err_cause;
                    op_cnt    = '0;
                    disc_next = !item.chunk_end;
                    restart   = 1'b1;
                end
                else if (item.chunk_end)
                begin
                    if (!restart && ((phase_next != PH_LEN) || (bcnt_next != 2'd0)))
                    begin
                        op_push  = 1'b1;
                        op       = '0;
                        op.op    = sld_pkg::OP_ERROR;
                        op.cause = sld_pkg::CAUSE_TRUNC;
                        op_cnt   = '0;
                    end
                    restart = 1'b1;
                end
            end
        end

        // Back to expecting a line length
        if (restart)
        begin
            phase_next   = PH_LEN;
            shift_next   = '0;
            bcnt_next    = 2'd0;
            runs_next    = '0;
            filled_next  = '0;
            wr_idx_next  = '0;
            emitted_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEN;
            shift_reg   <= '0;
            bcnt_reg    <= 2'd0;
            len_reg     <= '0;
            runs_reg    <= '0;
            filled_reg  <= '0;
            pfore_reg   <= '0;
            pback_reg   <= '0;
            pattr_reg   <= '0;
            wr_idx_reg  <= '0;
            emitted_reg <= '0;
            disc_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            bcnt_reg    <= bcnt_next;
            len_reg     <= len_next;
            runs_reg    <= runs_next;
            filled_reg  <= filled_next;
            pfore_reg   <= pfore_next;
            pback_reg   <= pback_next;
            pattr_reg   <= pattr_next;
            wr_idx_reg  <= wr_idx_next;
            emitted_reg <= emitted_next;
            disc_reg    <= disc_next;
        end
    end

    a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (phase_reg == PH_LEN) && (bcnt_reg == 2'd0))
        else $error("discarding while mid-line");

    a_filled_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= len_reg)
        else $error("runs cover more cells than the line holds");

    a_emitted_lt_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CODE) |-> (emitted_reg < len_reg))
        else $error("cell position past line end");

endmodule

### rtl/sld_back.sv
// Decoder back: run store writes, run lookup per cell and the result register.
module sld_back #(
    parameter int CNT_W = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sld_pkg::op_t       q_op,
    input  logic [CNT_W-1:0]   q_cnt,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output sld_pkg::res_t      res
);

    localparam int AW    = sld_pkg::STORE_AW;
    localparam int RUN_W = 80 + CNT_W;
    localparam int COL_W = sld_pkg::COL_W;

    // Run entry layout: fore, back, attr, end column
    localparam int END_LO  = 0;
    localparam int ATTR_LO = CNT_W;
    localparam int BACK_LO = CNT_W + 16;
    localparam int FORE_LO = CNT_W + 48;

    logic [RUN_W-1:0] cur_reg, cur_next;
    logic [RUN_W-1:0] nxt_reg, nxt_next;
    logic             cur_ok_reg, cur_ok_next;
    logic             nxt_ok_reg, nxt_ok_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_tgt_reg, rd_tgt_next;   // 1: load into next run
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic             res_valid_reg, res_valid_next;
    sld_pkg::res_t    res_reg, res_next;

    logic             slot_free;
    logic             is_start;
    logic             adv;
    logic             ok;
    logic             start_now;
    logic             emit;
    logic             issue;
    logic             wr_en;
    logic [RUN_W-1:0] wr_data;
    logic [RUN_W-1:0] rd_data;
    logic [RUN_W-1:0] use_run;
    logic [CNT_W+COL_W-1:0] cnt_ext;

    assign slot_free = !res_valid_reg || res_ready;
    assign is_start  = (q_op.op == sld_pkg::OP_START)
                    || ((q_op.op == sld_pkg::OP_RUN) && q_op.start);
    assign adv       = (q_cnt >= cur_reg[END_LO +: CNT_W]);
    assign use_run   = adv ? nxt_reg : cur_reg;
    assign cnt_ext   = {{COL_W{1'b0}}, q_cnt};

    // Can the head operation complete this cycle
    always_comb
    begin
        unique case (q_op.op)
            sld_pkg::OP_RUN:   ok = 1'b1;
            sld_pkg::OP_START: ok = 1'b1;
            sld_pkg::OP_CELL:  ok = slot_free && cur_ok_reg && (!adv || nxt_ok_reg);
            sld_pkg::OP_EMPTY: ok = slot_free;
            sld_pkg::OP_ERROR: ok = slot_free;
            default:           ok = 1'b0;
        endcase
    end

    assign q_pop     = q_valid && ok;
    assign start_now = q_pop && is_start;
    assign emit      = q_pop && ((q_op.op == sld_pkg::OP_CELL)
                              || (q_op.op == sld_pkg::OP_EMPTY)
                              || (q_op.op == sld_pkg::OP_ERROR));
    assign wr_en     = q_pop && (q_op.op == sld_pkg::OP_RUN);
    assign wr_data   = {q_op.data_a, q_op.data_b, q_op.attr, q_cnt};

    // Prefetch the current and next run of the line
    assign issue = !rd_pend_reg && !start_now && (!cur_ok_reg || !nxt_ok_reg);

    sld_ram #(
        .WIDTH (RUN_W),
        .DEPTH (sld_pkg::STORE_DEPTH)
    ) u_run_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (q_op.idx),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // Run window update
    always_comb
    begin
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        cur_ok_next  = cur_ok_reg;
        nxt_ok_next  = nxt_ok_reg;
        rd_pend_next = issue;
        rd_tgt_next  = issue ? cur_ok_reg : rd_tgt_reg;
        rd_addr_next = issue ? rd_addr_reg + 1'b1 : rd_addr_reg;
        if (start_now)
        begin
            cur_ok_next  = 1'b0;
            nxt_ok_next  = 1'b0;
            rd_addr_next = '0;
        end
        else
        begin
            if (rd_pend_reg)
            begin
                if (rd_tgt_reg)
                begin
                    nxt_next    = rd_data;
                    nxt_ok_next = 1'b1;
                end
                else
                begin
                    cur_next    = rd_data;
                    cur_ok_next = 1'b1;
                end
            end
            if (q_pop && (q_op.op == sld_pkg::OP_CELL) && adv)
            begin
                cur_next    = nxt_reg;
                nxt_ok_next = 1'b0;
            end
        end
    end

    // Result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (slot_free)
        begin
            res_valid_next = emit;
        end
        if (emit)
        begin
            res_next = '0;
            unique case (q_op.op)
                sld_pkg::OP_CELL:
                begin
                    res_next.kind         = sld_pkg::KIND_CELL;
                    res_next.char_code    = q_op.data_a;
                    res_next.fore_color   = use_run[FORE_LO +: 32];
                    res_next.back_color   = use_run[BACK_LO +: 32];
                    res_next.attr_bits    = use_run[ATTR_LO +: 16];
                    res_next.column       = cnt_ext[COL_W-1:0];
                    res_next.last_in_line = q_op.last;
                end
                sld_pkg::OP_EMPTY:
                begin
                    res_next.kind = sld_pkg::KIND_EMPTY;
                end
                default:
                begin
                    res_next.kind        = sld_pkg::KIND_ERROR;
                    res_next.error_cause = q_op.cause;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ok_reg    <= 1'b0;
            nxt_ok_reg    <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_tgt_reg    <= 1'b0;
            rd_addr_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_ok_reg    <= cur_ok_next;
            nxt_ok_reg    <= nxt_ok_next;
            rd_pend_reg   <= rd_pend_next;
            rd_tgt_reg    <= rd_tgt_next;
            rd_addr_reg   <= rd_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        nxt_reg <= nxt_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        nxt_ok_reg |-> cur_ok_reg)
        else $error("next run loaded without a current run");

endmodule

### dv/tb_style_run_line_decoder_unit.sv
// Self-checking testbench of the styled run line decoder: directed table, then random chunks.
module tb_style_run_line_decoder_unit;

    // Stop the random part once this many bytes in total went in
    localparam int RANDOM_ITEMS = 1200;
    // Cycles with no transaction on either channel before the run is called dead
    localparam int STALL_LIMIT  = 2000;
    // Settle time after the last expected result
    localparam int DRAIN_CYCLES = 16;

    // How a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,  // expectation comes from the line decoder model below
        CHK_QUIET,    // pinned: no result
        CHK_RESULT    // pinned: the result given in the row
    } row_check_t;

    // Parser position of the model
    typedef enum logic [2:0] {
        AT_LENGTH,
        AT_NRUNS,
        AT_FORE,
        AT_BACK,
        AT_ATTR,
        AT_COUNT,
        AT_CODE
    } parse_phase_t;

    // Defects injected into generated lines
    typedef enum int {
        FLAW_NONE,
        FLAW_OVERFLOW,
        FLAW_SHORT,
        FLAW_TOO_LONG
    } line_flaw_t;

    typedef struct packed {
        sld_pkg::item_t it;
        row_check_t     check;
        sld_pkg::res_t  res;
    } plan_row_t;

    localparam sld_pkg::res_t NO_RES     = '0;
    localparam sld_pkg::res_t ERR_TRUNC  =
        '{kind: sld_pkg::KIND_ERROR, error_cause: sld_pkg::CAUSE_TRUNC, default: '0};
    localparam sld_pkg::res_t ERR_SHORT  =
        '{kind: sld_pkg::KIND_ERROR, error_cause: sld_pkg::CAUSE_SHORT, default: '0};
    localparam sld_pkg::res_t ERR_LONG   =
        '{kind: sld_pkg::KIND_ERROR, error_cause: sld_pkg::CAUSE_TOO_LONG, default: '0};
    localparam sld_pkg::res_t EMPTY_MARK = '{kind: sld_pkg::KIND_EMPTY, default: '0};

    // Directed bytes, little-endian words
    localparam int PLAN_LEN = 27;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // one-byte chunk right after reset: line length cut off
        '{'{8'h00, 1'b1}, CHK_RESULT, ERR_TRUNC},
        // length 1025, one past the limit
        '{'{8'h01, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h04, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_RESULT, ERR_LONG},
        // dropped until and including the chunk end
        '{'{8'hFF, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'hAA, 1'b1}, CHK_QUIET,  NO_RES},
        // zero-length line with no runs
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_RESULT, EMPTY_MARK},
        // length 1 but no runs, caught on the chunk end byte
        '{'{8'h01, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b1}, CHK_RESULT, ERR_SHORT},
        // length exactly at the limit, then the chunk ends
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h04, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b0}, CHK_QUIET,  NO_RES},
        '{'{8'h00, 1'b1}, CHK_RESULT, ERR_TRUNC}
    };

    logic           clk        = 1'b0;
    logic           rst_n      = 1'b0;
    logic           item_valid = 1'b0;
    logic           item_ready;
    sld_pkg::item_t item       = '0;
    logic           res_valid;
    logic           res_ready  = 1'b0;
    sld_pkg::res_t  res;

    style_run_line_decoder_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Line decoder model state
    parse_phase_t                 dec_phase;
    logic [31:0]                  dec_shift;
    int unsigned                  dec_nbytes;
    logic [31:0]                  dec_length;
    logic [31:0]                  dec_runs_left;
    logic [31:0]                  dec_filled;
    logic [31:0]                  dec_fore;
    logic [31:0]                  dec_back;
    logic [15:0]                  dec_attr;
    logic [sld_pkg::STORE_AW-1:0] dec_run;
    logic [31:0]                  dec_emitted;
    bit                           dec_dropping;
    logic [31:0]                  saved_fore [sld_pkg::STORE_DEPTH];
    logic [31:0]                  saved_back [sld_pkg::STORE_DEPTH];
    logic [15:0]                  saved_attr [sld_pkg::STORE_DEPTH];
    logic [31:0]                  saved_end  [sld_pkg::STORE_DEPTH];

    sld_pkg::res_t outputs_due [$];
    logic [7:0]    chunk_q [$];
    int            fail_count   = 0;
    int            live_items   = 0;
    bit            send_choppy  = 1'b0;
    int            quiet_cycles = 0;
    int            sink_hold    = 0;
    int            sink_span    = 0;
    bit            sink_calm    = 1'b1;

    function automatic void restart_line();
        dec_phase     = AT_LENGTH;
        dec_shift     = '0;
        dec_nbytes    = 0;
        dec_runs_left = '0;
        dec_filled    = '0;
        dec_run       = '0;
        dec_emitted   = '0;
    endfunction

    // Advance the model by one byte; returns 1 when the byte yields a result
    function automatic bit decode_byte(input sld_pkg::item_t it, output sld_pkg::res_t r);
        logic [31:0]                  word;
        int unsigned                  need;
        bit                           has_err;
        logic [1:0]                   cause;
        bit                           got;
        bit                           last;
        logic [sld_pkg::STORE_AW-1:0] idx;
        r       = '0;
        got     = 1'b0;
        has_err = 1'b0;
        cause   = sld_pkg::CAUSE_TRUNC;
        if (dec_dropping)
        begin
            if (it.chunk_end)
            begin
                dec_dropping = 1'b0;
                restart_line();
            end
            return 1'b0;
        end
        dec_shift = {it.in_byte, dec_shift[31:8]};
        need      = (dec_phase == AT_ATTR) ? 2 : 4;
        dec_nbytes++;
        if (dec_nbytes >= need)
        begin
            dec_nbytes = 0;
            word       = (need == 2) ? {16'h0, dec_shift[31:16]} : dec_shift;
            case (dec_phase)
                AT_NRUNS, AT_COUNT:
                begin
                    if (dec_phase == AT_COUNT &&
                        64'(dec_filled) + 64'(word) > 64'(dec_length))
                    begin
                        has_err = 1'b1;
                        cause   = sld_pkg::CAUSE_OVERFLOW;
                    end
                    else
                    begin
                        if (dec_phase == AT_NRUNS)
                        begin
                            dec_runs_left = word;
                            dec_filled    = '0;
                            dec_run       = '0;
                        end
                        else
                        begin
                            // zero-count runs are not stored
                            if (word != 0)
                            begin
                                dec_filled          += word;
                                saved_fore[dec_run] = dec_fore;
                                saved_back[dec_run] = dec_back;
                                saved_attr[dec_run] = dec_attr;
                                saved_end[dec_run]  = dec_filled;
                                dec_run++;
                            end
                            dec_runs_left--;
                        end
                        if (dec_runs_left != 0)
                            dec_phase = AT_FORE;
                        else if (dec_filled != dec_length)
                        begin
                            has_err = 1'b1;
                            cause   = sld_pkg::CAUSE_SHORT;
                        end
                        else if (dec_length == 0)
                        begin
                            r      = '0;
                            r.kind = sld_pkg::KIND_EMPTY;
                            got    = 1'b1;
                            restart_line();
                        end
                        else
                        begin
                            dec_phase   = AT_CODE;
                            dec_run     = '0;
                            dec_emitted = '0;
                        end
                    end
                end
                AT_FORE:
                begin
                    dec_fore  = word;
                    dec_phase = AT_BACK;
                end
                AT_BACK:
                begin
                    dec_back  = word;
                    dec_phase = AT_ATTR;
                end
                AT_ATTR:
                begin
                    dec_attr  = word[15:0];
                    dec_phase = AT_COUNT;
                end
                AT_CODE:
                begin
                    // step to the next run once its end column is reached
                    idx = dec_run;
                    if (dec_emitted >= saved_end[idx])
                    begin
                        dec_run++;
                        idx = dec_run;
                    end
                    last           = (dec_emitted + 32'd1 == dec_length);
                    r              = '0;
                    r.kind         = sld_pkg::KIND_CELL;
                    r.char_code    = word;
                    r.fore_color   = saved_fore[idx];
                    r.back_color   = saved_back[idx];
                    r.attr_bits    = saved_attr[idx];
                    r.column       = dec_emitted[sld_pkg::COL_W-1:0];
                    r.last_in_line = last;
                    got            = 1'b1;
                    dec_emitted++;
                    if (last)
                        restart_line();
                end
                default:
                begin
                    if (word > 32'(sld_pkg::MAX_LINE_DEF))
                    begin
                        has_err = 1'b1;
                        cause   = sld_pkg::CAUSE_TOO_LONG;
                    end
                    else
                    begin
                        dec_length = word;
                        dec_phase  = AT_NRUNS;
                    end
                end
            endcase
        end
        // errors win over a cut-off line; chunk end always resyncs
        if (has_err)
        begin
            r             = '0;
            r.kind        = sld_pkg::KIND_ERROR;
            r.error_cause = cause;
            got           = 1'b1;
            dec_dropping  = !it.chunk_end;
            restart_line();
        end
        else if (it.chunk_end)
        begin
            if (dec_phase != AT_LENGTH || dec_nbytes != 0)
            begin
                r             = '0;
                r.kind        = sld_pkg::KIND_ERROR;
                r.error_cause = sld_pkg::CAUSE_TRUNC;
                got           = 1'b1;
            end
            restart_line();
        end
        return got;
    endfunction

    function automatic void report(input string what, input sld_pkg::res_t want,
                                   input sld_pkg::res_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $time, what);
            $display("  want kind=%0d cause=%0d code=%h fore=%h back=%h attr=%h col=%0d last=%0b",
                     want.kind, want.error_cause, want.char_code, want.fore_color,
                     want.back_color, want.attr_bits, want.column, want.last_in_line);
            $display("  got  kind=%0d cause=%0d code=%h fore=%h back=%h attr=%h col=%0d last=%0b",
                     got.kind, got.error_cause, got.char_code, got.fore_color,
                     got.back_color, got.attr_bits, got.column, got.last_in_line);
        end
    endfunction

    // Compare one result transaction with the oldest expectation
    function automatic void check_result(input sld_pkg::res_t got);
        sld_pkg::res_t want;
        string         diff;
        if (outputs_due.size() == 0)
        begin
            report("result with nothing pending", NO_RES, got);
            return;
        end
        want = outputs_due[0];
        outputs_due.delete(0);
        diff = "";
        if (got.kind !== want.kind)                 diff = {diff, " kind"};
        if (got.error_cause !== want.error_cause)   diff = {diff, " error_cause"};
        if (got.char_code !== want.char_code)       diff = {diff, " char_code"};
        if (got.fore_color !== want.fore_color)     diff = {diff, " fore_color"};
        if (got.back_color !== want.back_color)     diff = {diff, " back_color"};
        if (got.attr_bits !== want.attr_bits)       diff = {diff, " attr_bits"};
        if (got.column !== want.column)             diff = {diff, " column"};
        if (got.last_in_line !== want.last_in_line) diff = {diff, " last_in_line"};
        if (diff != "")
            report({"field mismatch:", diff}, want, got);
    endfunction

    function automatic int sender_gap();
        int roll;
        if (!send_choppy)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one input transaction, then log what it should produce
    task automatic drive_byte(input sld_pkg::item_t it, input row_check_t how,
                              input sld_pkg::res_t pinned);
        int            gap;
        bit            yields;
        sld_pkg::res_t predicted;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        live_items++;
        yields = decode_byte(it, predicted);
        case (how)
            CHK_PREDICT: if (yields) outputs_due.insert(outputs_due.size(), predicted);
            CHK_RESULT:  outputs_due.insert(outputs_due.size(), pinned);
            default:     ;
        endcase
    endtask

    function automatic void put_word(input logic [31:0] w, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            chunk_q.insert(chunk_q.size(), w[8*i +: 8]);
    endfunction

    function automatic logic [31:0] style_color();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return 32'h0000_0000;
        if (roll == 1)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // Append one encoded line, optionally with a defect
    function automatic void build_line(input line_flaw_t flaw, input int len,
                                       input bit unit_runs);
        logic [31:0] counts [$];
        int          left;
        int          pos;
        logic [31:0] step;
        logic [31:0] head_sum;
        if (flaw == FLAW_TOO_LONG)
        begin
            put_word(($urandom_range(0, 1) != 0) ? 32'(sld_pkg::MAX_LINE_DEF + 1)
                                                 : ($urandom() | 32'h0000_0800), 4);
            repeat ($urandom_range(0, 6))
                chunk_q.insert(chunk_q.size(), 8'($urandom()));
            return;
        end
        // split the length into runs, sprinkling zero-count runs
        left = len;
        while (left > 0)
        begin
            if ($urandom_range(0, 5) == 0)
                counts.insert(counts.size(), 32'd0);
            step = unit_runs ? 32'd1 : 32'($urandom_range(1, left));
            counts.insert(counts.size(), step);
            left -= int'(step);
        end
        if ($urandom_range(0, 7) == 0)
            counts.insert(counts.size(), 32'd0);
        if (flaw == FLAW_OVERFLOW)
        begin
            if (counts.size() == 0)
                counts.insert(counts.size(), 32'd0);
            pos      = $urandom_range(0, counts.size() - 1);
            head_sum = '0;
            for (int i = 0; i < pos; i++)
                head_sum += counts[i];
            counts[pos] = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF
                          : 32'(len) - head_sum + 32'($urandom_range(1, 8));
        end
        else if (flaw == FLAW_SHORT)
        begin
            pos = counts.size() - 1;
            while (counts[pos] == 0)
                pos--;
            counts[pos] = $urandom_range(0, counts[pos] - 1);
        end
        put_word(32'(len), 4);
        put_word(32'(counts.size()), 4);
        foreach (counts[i])
        begin
            put_word(style_color(), 4);
            put_word(style_color(), 4);
            put_word($urandom(), 2);
            put_word(counts[i], 4);
        end
        if (flaw == FLAW_NONE)
            repeat (len) put_word($urandom(), 4);
    endfunction

    // One chunk: a few lines, mostly clean; a cut line or noise closes it
    function automatic void build_chunk();
        int lines;
        int pick;
        int len;
        int mark;
        int cut;
        lines = $urandom_range(1, 3);
        for (int n = 0; n < lines; n++)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(0, 99);
            if (len < 10)
                len = 0;
            else if (len < 80)
                len = $urandom_range(1, 6);
            else if (len < 97)
                len = $urandom_range(7, 30);
            else
                len = $urandom_range(31, 120);
            if (pick < 72)
                build_line(FLAW_NONE, len, 1'b0);
            else if (pick < 78)
                build_line(FLAW_OVERFLOW, len, 1'b0);
            else if (pick < 84)
                build_line(FLAW_SHORT, (len == 0) ? 1 : len, 1'b0);
            else if (pick < 89)
                build_line(FLAW_TOO_LONG, 0, 1'b0);
            else if (pick < 95)
            begin
                mark = chunk_q.size();
                build_line(FLAW_NONE, len, 1'b0);
                cut = $urandom_range(mark + 1, chunk_q.size() - 1);
                while (chunk_q.size() > cut)
                    chunk_q.delete(chunk_q.size() - 1);
                break;
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    chunk_q.insert(chunk_q.size(), 8'($urandom()));
                break;
            end
        end
    endfunction

    task automatic send_chunk();
        sld_pkg::item_t it;
        send_choppy = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < chunk_q.size(); i++)
        begin
            it.in_byte   = chunk_q[i];
            it.chunk_end = (i == chunk_q.size() - 1);
            drive_byte(it, CHK_PREDICT, NO_RES);
        end
        chunk_q.delete();
    endtask

    // Result side: calm stretches alternate with choppy ones
    always @(negedge clk)
    begin
        if (sink_span == 0)
        begin
            sink_calm = ($urandom_range(0, 2) == 0);
            sink_span = $urandom_range(50, 400);
        end
        sink_span--;
        if (sink_hold > 0)
        begin
            sink_hold--;
            res_ready <= 1'b0;
        end
        else if (!sink_calm && $urandom_range(0, 9) < 3)
        begin
            sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            check_result(res);
    end

    // Watchdog: no transaction on either side for too long
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        dec_length   = '0;
        dec_fore     = '0;
        dec_back     = '0;
        dec_attr     = '0;
        dec_dropping = 1'b0;
        restart_line();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
            drive_byte(PLAN[i].it, PLAN[i].check, PLAN[i].res);

        // random chunks
        while (live_items < RANDOM_ITEMS)
        begin
            build_chunk();
            send_chunk();
        end
        @(negedge clk);
        item_valid <= 1'b0;

        while (outputs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/sld_pkg.sv
rtl/sld_ram.sv
rtl/sld_queue.sv
rtl/sld_front.sv
rtl/sld_back.sv
rtl/style_run_line_decoder_unit.sv
dv/tb_style_run_line_decoder_unit.sv
